@@ rtl/core/fcq_pkg.sv @@
`default_nettype none

package fcq_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int ITEM_W         = 32;
    localparam int FUNC_W         = 2;
    localparam int CAP_W          = 9;
    localparam int STATUS_W       = 2;
    localparam int CAP_RESET      = 256;

    typedef enum logic [FUNC_W-1:0] {
        FN_ENQ  = 2'd0,
        FN_DEQ  = 2'd1,
        FN_PEEK = 2'd2,
        FN_CLR  = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

endpackage

`default_nettype wire

@@ rtl/core/fcq_mem.sv @@
`default_nettype none

module fcq_mem #(
    parameter int DEPTH      = fcq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = fcq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DATA_WIDTH-1:0]    i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [DATA_WIDTH-1:0]    o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/fcq_ctrl.sv @@
`default_nettype none

module fcq_ctrl #(
    parameter int DEPTH      = fcq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = fcq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_cfg_we,
    input  wire logic [fcq_pkg::CAP_W-1:0]     i_cfg_wdata,
    input  wire logic [fcq_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [fcq_pkg::ITEM_W-1:0]    i_item_in,
    output logic                               o_mem_we,
    output logic      [$clog2(DEPTH)-1:0]      o_mem_waddr,
    output logic      [DATA_WIDTH-1:0]         o_mem_wdata,
    output logic      [$clog2(DEPTH)-1:0]      o_mem_raddr,
    input  wire logic [DATA_WIDTH-1:0]         i_mem_rdata,
    output logic                               o_valid,
    output logic      [fcq_pkg::ITEM_W-1:0]    o_item_out,
    output logic      [fcq_pkg::STATUS_W-1:0]  o_status,
    output logic      [fcq_pkg::CAP_W-1:0]     o_fill_count,
    output logic                               o_empty_flag,
    output logic                               o_is_full
);

    localparam int PW        = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CMP_W     = ((CNT_W > fcq_pkg::CAP_W) ? CNT_W : fcq_pkg::CAP_W) + 1;
    localparam int CAP_INIT  = (fcq_pkg::CAP_RESET > DEPTH) ? DEPTH : fcq_pkg::CAP_RESET;

    fcq_pkg::t_state  r_state, n_state;
    fcq_pkg::t_func   r_func;
    logic [DATA_WIDTH-1:0] r_item;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0] r_occ, n_occ;
    logic [CNT_W-1:0] r_cap, n_cap;

    logic                     r_valid;
    logic [fcq_pkg::ITEM_W-1:0] r_item_out;
    fcq_pkg::t_status         r_status;
    logic [fcq_pkg::CAP_W-1:0] r_fill;
    logic                     r_empty;
    logic                     r_full;

    logic             accept;
    logic             ex_we;
    fcq_pkg::t_status ex_status;
    logic [DATA_WIDTH-1:0] ex_item;
    logic [CNT_W-1:0] rd_inc, wr_inc;
    logic [PW-1:0]    rd_adv, wr_adv;
    logic [CMP_W-1:0] cfg_wide;

    assign accept = start && (r_state == fcq_pkg::S_IDLE);

    // Pointers wrap at the capacity by compare.
    assign rd_inc = CNT_W'(r_rd_ptr) + CNT_W'(1);
    assign wr_inc = CNT_W'(r_wr_ptr) + CNT_W'(1);
    assign rd_adv = (rd_inc >= r_cap) ? '0 : PW'(rd_inc);
    assign wr_adv = (wr_inc >= r_cap) ? '0 : PW'(wr_inc);

    // Clamp the written capacity to the range one to DEPTH.
    assign cfg_wide = CMP_W'(i_cfg_wdata);
    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_cap = CNT_W'(1);
        end else if (cfg_wide > CMP_W'(DEPTH)) begin
            n_cap = CNT_W'(DEPTH);
        end else begin
            n_cap = CNT_W'(cfg_wide);
        end
    end

    // Operation on the registered request; memory data reflects r_rd_ptr.
    always_comb begin
        n_rd_ptr  = r_rd_ptr;
        n_wr_ptr  = r_wr_ptr;
        n_occ     = r_occ;
        ex_we     = 1'b0;
        ex_status = fcq_pkg::ST_OK;
        ex_item   = '0;
        case (r_func)
            fcq_pkg::FN_ENQ: begin
                if (r_occ >= r_cap) begin
                    ex_status = fcq_pkg::ST_FULL;
                end else begin
                    ex_we    = 1'b1;
                    n_wr_ptr = wr_adv;
                    n_occ    = r_occ + CNT_W'(1);
                end
            end
            fcq_pkg::FN_DEQ: begin
                if (r_occ == '0) begin
                    ex_status = fcq_pkg::ST_EMPTY;
                end else begin
                    ex_item  = i_mem_rdata;
                    n_rd_ptr = rd_adv;
                    n_occ    = r_occ - CNT_W'(1);
                end
            end
            fcq_pkg::FN_PEEK: begin
                if (r_occ == '0) begin
                    ex_status = fcq_pkg::ST_EMPTY;
                end else begin
                    ex_item = i_mem_rdata;
                end
            end
            default: begin
                n_rd_ptr = r_wr_ptr;
                n_occ    = '0;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            fcq_pkg::S_IDLE: n_state = accept ? fcq_pkg::S_EXEC : fcq_pkg::S_IDLE;
            fcq_pkg::S_EXEC: n_state = fcq_pkg::S_IDLE;
            default:         n_state = fcq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        busy        = (r_state == fcq_pkg::S_EXEC);
        o_mem_we    = (r_state == fcq_pkg::S_EXEC) && ex_we;
        o_mem_waddr = r_wr_ptr;
        o_mem_wdata = r_item;
        o_mem_raddr = r_rd_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fcq_pkg::S_IDLE;
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_occ    <= '0;
            r_cap    <= CNT_W'(CAP_INIT);
            r_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == fcq_pkg::S_EXEC);
            if (i_cfg_we) begin
                r_cap    <= n_cap;
                r_rd_ptr <= '0;
                r_wr_ptr <= '0;
                r_occ    <= '0;
            end else if (r_state == fcq_pkg::S_EXEC) begin
                r_rd_ptr <= n_rd_ptr;
                r_wr_ptr <= n_wr_ptr;
                r_occ    <= n_occ;
            end
        end
    end

    // Hold the request payload and the result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= fcq_pkg::t_func'(i_func);
            r_item <= DATA_WIDTH'(i_item_in);
        end
        if (r_state == fcq_pkg::S_EXEC) begin
            r_item_out <= fcq_pkg::ITEM_W'(ex_item);
            r_status   <= ex_status;
            r_fill     <= fcq_pkg::CAP_W'(n_occ);
            r_empty    <= (n_occ == '0);
            r_full     <= (n_occ == r_cap);
        end
    end

    assign o_valid      = r_valid;
    assign o_item_out   = r_item_out;
    assign o_status     = r_status;
    assign o_fill_count = r_fill;
    assign o_empty_flag = r_empty;
    assign o_is_full    = r_full;

endmodule

`default_nettype wire

@@ rtl/core/circular_fifo_queue_core.sv @@
// A request accepted in S_IDLE moves the control to S_EXEC, where busy is high;
// the result registers then present its result with o_valid.
// A new request is taken only in S_IDLE; start is ignored while busy is high.
// Reset: synchronous, active low; clears pointers, fill count and o_valid;
// capacity 256, or DEPTH where DEPTH is smaller.
// The receiver cannot stall: each result is presented for exactly one cycle.
`default_nettype none

module circular_fifo_queue_core #(
    parameter int DEPTH      = fcq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = fcq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_cfg_we,
    input  wire logic [fcq_pkg::CAP_W-1:0]     i_cfg_wdata,
    input  wire logic [fcq_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [fcq_pkg::ITEM_W-1:0]    i_item_in,
    output logic                               o_valid,
    output logic      [fcq_pkg::ITEM_W-1:0]    o_item_out,
    output logic      [fcq_pkg::STATUS_W-1:0]  o_status,
    output logic      [fcq_pkg::CAP_W-1:0]     o_fill_count,
    output logic                               o_empty_flag,
    output logic                               o_is_full
);

    logic                     mem_we;
    logic [$clog2(DEPTH)-1:0] mem_waddr;
    logic [DATA_WIDTH-1:0]    mem_wdata;
    logic [$clog2(DEPTH)-1:0] mem_raddr;
    logic [DATA_WIDTH-1:0]    mem_rdata;

    fcq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_func       (i_func),
        .i_item_in    (i_item_in),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata),
        .o_valid      (o_valid),
        .o_item_out   (o_item_out),
        .o_status     (o_status),
        .o_fill_count (o_fill_count),
        .o_empty_flag (o_empty_flag),
        .o_is_full    (o_is_full)
    );

    fcq_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

@@ rtl/core/fcq_checker.sv @@
`default_nettype none

module fcq_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          o_valid,
    input wire logic [fcq_pkg::ITEM_W-1:0]    o_item_out,
    input wire logic [fcq_pkg::STATUS_W-1:0]  o_status,
    input wire logic [fcq_pkg::CAP_W-1:0]     o_fill_count,
    input wire logic                          o_empty_flag,
    input wire logic                          o_is_full
);

    // Every accepted request raises busy and then yields a result with o_valid.
    a_req_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy ##1 o_valid)
        else $error("accepted request did not produce a result on time");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) && !busy))
        else $error("result strobe without a preceding busy cycle");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_empty_flag == (o_fill_count == '0)))
        else $error("empty flag disagrees with fill count");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != fcq_pkg::ST_OK)) |-> (o_item_out == '0))
        else $error("refused request returned nonzero data");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == fcq_pkg::ST_FULL)) |-> (o_is_full && !o_empty_flag))
        else $error("full refusal while queue not reported full");

endmodule

bind circular_fifo_queue_core fcq_checker u_fcq_checker (.*);

`default_nettype wire
